// ----- rtl/core/assert_macros.svh -----
// Assertion macros for base64_codec_top, the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ----- rtl/core/b64_pkg.sv -----
// Package of the Base64 codec: types, the pad character and alphabet functions.
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [1:0]  pos;
    logic [23:0] held;
    logic        third_pad;
  } st_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
    logic       length_error;
  } res_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = {2'b00, v} + 8'd65;
    end else if (v < 6'd52) begin
      r = {2'b00, v} + 8'd71;
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Anything outside the alphabet, the pad character included, maps to zero.
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 6'(c - 8'd65);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 6'(c + 8'd4);
    end else if (c == 8'h2B) begin
      r = 6'd62;
    end else if (c == 8'h2F) begin
      r = 6'd63;
    end else begin
      r = 6'd0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64_if.sv -----
// Stream interfaces of the Base64 codec: the input channel and the result channel.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_last;

  modport source (output valid, output in_byte, output stream_last, input ready);
  modport sink (input valid, input in_byte, input stream_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       stream_end;
  logic       length_error;

  modport source (output valid, output out_byte, output run_end, output stream_end,
                  output length_error, input ready);
  modport sink (input valid, input out_byte, input run_end, input stream_end,
                input length_error, output ready);
endinterface

// ----- rtl/core/base64_codec_top.sv -----
// Top level of the streaming Base64 codec: input register, step logic and result buffer.
//
//  channel   role    payload
//  in_ch     sink    in_byte, stream_last
//  out_ch    source  out_byte, run_end, stream_end, length_error
//  cfg       write   cfg_wdata (direction), strobe cfg_we
//
// A byte is held in the input register until the step logic loads all of its
// results (up to four) into the result buffer at once.
// The result buffer sends one beat a cycle while out_ch.ready is high, through the
// single result port, so a byte's results leave one at a time.
// A new byte is taken while results wait; it enters the step as the last one drains.
// Synchronous reset clears direction, group state and both valid flags.
module base64_codec_top
  import b64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  b64_in_if.sink      in_ch,
  b64_out_if.source   out_ch
);

  `include "assert_macros.svh"

  logic        dir;
  st_t         st;
  st_t         st_next;
  logic        ivld;
  logic [7:0]  ibyte;
  logic        ilast;
  res_t [3:0]  ent;
  res_t [3:0]  step_res;
  logic [2:0]  step_n;
  logic [2:0]  cnt;
  logic        take;
  logic        fire;

  b64_step u_step (
    .st      (st),
    .dir     (dir),
    .in_byte (ibyte),
    .last    (ilast),
    .st_next (st_next),
    .res     (step_res),
    .n       (step_n)
  );

  assign take = (cnt != 3'd0) && out_ch.ready;
  assign fire = ivld && ((cnt == 3'd0) || (cnt == 3'd1 && take));

  assign in_ch.ready         = !ivld || fire;
  assign out_ch.valid        = (cnt != 3'd0);
  assign out_ch.out_byte     = ent[0].out_byte;
  assign out_ch.run_end      = ent[0].run_end;
  assign out_ch.stream_end   = ent[0].stream_end;
  assign out_ch.length_error = ent[0].length_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir  <= 1'b0;
      st   <= '0;
      ivld <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      if (cfg_we) begin
        dir <= cfg_wdata;
        st  <= '0;
      end else if (fire) begin
        st <= st_next;
      end
      if (in_ch.valid && in_ch.ready) begin
        ivld <= 1'b1;
      end else if (fire) begin
        ivld <= 1'b0;
      end
      if (fire) begin
        cnt <= step_n;
      end else if (take) begin
        cnt <= cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ibyte <= in_ch.in_byte;
      ilast <= in_ch.stream_last;
    end
    if (fire) begin
      ent <= step_res;
    end else if (take) begin
      ent <= {ent[3], ent[3:1]};
    end
  end

  `AST_IMPL(a_cnt_range, clk, rst, 1'b1, cnt <= 3'd4)
  `AST_NEXT(a_load_count, clk, rst, fire, cnt == $past(step_n))
  `AST_NEXT(a_last_clears, clk, rst, fire && ilast && !cfg_we, st == '0)
  `AST_IMPL(a_error_beat, clk, rst, out_ch.valid && out_ch.length_error,
            out_ch.run_end && out_ch.stream_end && out_ch.out_byte == 8'h00)

endmodule

// ----- rtl/core/b64_step.sv -----
// Combinational step of the codec: next group state and up to four results per byte.
module b64_step
  import b64_pkg::*;
(
  input  st_t             st,
  input  logic            dir,
  input  logic [7:0]      in_byte,
  input  logic            last,
  output st_t             st_next,
  output res_t [3:0]      res,
  output logic [2:0]      n
);

  always_comb begin
    logic [5:0]  s;
    logic [23:0] held;
    logic [1:0]  pad;
    logic        is_pad;
    st_next = st;
    res     = '0;
    n       = 3'd0;
    is_pad  = (in_byte == PAD_CHAR);
    held    = st.held;
    s       = sextet_of(in_byte);
    pad     = 2'd0;
    if (!dir) begin
      unique case (st.pos)
        2'd0: begin
          held = {in_byte, 16'h0000};
          res[0].out_byte = enc_char(held[23:18]);
          n = 3'd1;
          st_next.pos = 2'd1;
          if (last) begin
            res[1].out_byte = enc_char(held[17:12]);
            res[2].out_byte = PAD_CHAR;
            res[3].out_byte = PAD_CHAR;
            n = 3'd4;
          end
        end
        2'd1: begin
          held = {st.held[23:16], in_byte, 8'h00};
          res[0].out_byte = enc_char(held[17:12]);
          n = 3'd1;
          st_next.pos = 2'd2;
          if (last) begin
            res[1].out_byte = enc_char(held[11:6]);
            res[2].out_byte = PAD_CHAR;
            n = 3'd3;
          end
        end
        default: begin
          held = {st.held[23:8], in_byte};
          res[0].out_byte = enc_char(held[11:6]);
          res[1].out_byte = enc_char(held[5:0]);
          n = 3'd2;
          st_next.pos = 2'd0;
        end
      endcase
    end else begin
      unique case (st.pos)
        2'd0: begin
          held = {s, 18'h00000};
          st_next.third_pad = 1'b0;
          st_next.pos = 2'd1;
        end
        2'd1: begin
          held = st.held | {6'h00, s, 12'h000};
          st_next.pos = 2'd2;
        end
        2'd2: begin
          held = st.held | {12'h000, s, 6'h00};
          st_next.third_pad = is_pad;
          st_next.pos = 2'd3;
        end
        default: begin
          held = st.held | {18'h00000, s};
          st_next.pos = 2'd0;
          if (last) begin
            pad = {1'b0, is_pad} + {1'b0, st.third_pad};
          end
          res[0].out_byte = held[23:16];
          res[1].out_byte = held[15:8];
          res[2].out_byte = held[7:0];
          n = 3'd3 - {1'b0, pad};
        end
      endcase
      // A stream that stops inside a group yields a single error beat.
      if (st.pos != 2'd3 && last) begin
        res[0].length_error = 1'b1;
        n = 3'd1;
      end
    end
    st_next.held = held;
    if (last) begin
      st_next = '0;
    end
    for (int i = 0; i < 4; i++) begin
      res[i].run_end    = (3'(i) == n - 3'd1);
      res[i].stream_end = (3'(i) == n - 3'd1) && last;
    end
  end

endmodule
